// ===== hw/rtl/kls_pkg.sv =====
package kls_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 5;

  typedef struct packed {
    logic signed [VALUE_W-1:0] kth_value;
    logic                      short_set;
  } result_t;

endpackage

// ===== hw/rtl/kls_in_if.sv =====
interface kls_in_if
  import kls_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] sample_value;
  logic                      set_end;

  modport source (output valid, output sample_value, output set_end, input ready);
  modport sink (input valid, input sample_value, input set_end, output ready);
endinterface

// ===== hw/rtl/kls_out_if.sv =====
interface kls_out_if
  import kls_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] kth_value;
  logic                      short_set;

  modport source (output valid, output kth_value, output short_set, input ready);
  modport sink (input valid, input kth_value, input short_set, output ready);
endinterface

// ===== hw/rtl/kth_largest_selector.sv =====
// k-th largest selector: takes one signed 32-bit value per transfer on samples and keeps the
// rank_k largest values of the current set, sorted high to low in a small store (equal values
// count separately). On the transfer marked set_end the smallest kept value, i.e. the k-th
// largest of the set, goes out on results; short_set flags a set with fewer than k values, and
// the store is then emptied for the next set. rank_k of zero acts as 1, above KEEP_MAX it
// saturates. Each value is handled by one comparator and one store port walking the kept list
// from its smallest end, one entry per cycle: an item passes a start state, a full-store check
// when the store is full (a value that does not beat the smallest is dropped there), steps that
// move smaller entries down and write the value, and a finish state; a set end adds a fetch.
// samples is not ready while an item is being worked; a finished result waits in an output
// register so the next set can start. The store needs no clearing after reset.
module kth_largest_selector
  import kls_pkg::*;
#(
  parameter int KEEP_MAX = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [RANK_W-1:0] cfg_wdata,
  kls_in_if.sink            samples,
  kls_out_if.source         results
);

  localparam int CW = $clog2(KEEP_MAX + 1);
  localparam int AW = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;

  // rank register, resets to 1 (the maximum value)
  logic [RANK_W-1:0] rank_k;
  logic [31:0]       rank_wide;
  logic [31:0]       k_wide;
  logic [CW-1:0]     k_eff;

  // sequencer to store
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic signed [VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]             mem_raddr;
  logic signed [VALUE_W-1:0] mem_rdata;

  // result handoff
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_data;
  logic    out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_k <= RANK_W'(1);
    end else if (cfg_we) begin
      rank_k <= cfg_wdata;
    end
  end

  // zero means the maximum, large ranks clamp to the store depth
  always_comb begin
    rank_wide = 32'(rank_k);
    if (rank_wide == '0) begin
      k_wide = 32'd1;
    end else if (rank_wide > 32'(KEEP_MAX)) begin
      k_wide = 32'(KEEP_MAX);
    end else begin
      k_wide = rank_wide;
    end
  end

  assign k_eff = k_wide[CW-1:0];

  kls_seq #(
    .KEEP_MAX (KEEP_MAX)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .in_value  (samples.sample_value),
    .in_last   (samples.set_end),
    .k_eff     (k_eff),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  kls_store #(
    .DEPTH (KEEP_MAX)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: loads whenever it is empty or being drained this cycle
  assign res_ready = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
    if (res_valid && res_ready) begin
      out_data <= res;
    end
  end

  assign results.valid     = out_valid;
  assign results.kth_value = out_data.kth_value;
  assign results.short_set = out_data.short_set;

endmodule

// ===== hw/rtl/kls_store.sv =====
module kls_store
  import kls_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic signed [VALUE_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic signed [VALUE_W-1:0] rdata
);

  // kept values in descending order, read data registered
  logic signed [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/kls_seq.sv =====
module kls_seq
  import kls_pkg::*;
#(
  parameter int KEEP_MAX = 16,
  localparam int CW = $clog2(KEEP_MAX + 1),
  localparam int AW = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic                      in_last,
  input  logic [CW-1:0]             k_eff,
  output logic                      res_valid,
  input  logic                      res_ready,
  output result_t                   res,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic signed [VALUE_W-1:0] mem_wdata,
  output logic [AW-1:0]             mem_raddr,
  input  logic signed [VALUE_W-1:0] mem_rdata
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_START   = 3'd1;
  localparam logic [2:0] S_CHKFULL = 3'd2;
  localparam logic [2:0] S_STEP    = 3'd3;
  localparam logic [2:0] S_PLACE   = 3'd4;
  localparam logic [2:0] S_FINISH  = 3'd5;
  localparam logic [2:0] S_FETCH   = 3'd6;

  logic [2:0]                state, state_next;
  logic [CW-1:0]             count, count_next;
  logic [CW-1:0]             kq, kq_next;
  logic [AW-1:0]             i, i_next;
  logic [AW-1:0]             i_dec;
  logic signed [VALUE_W-1:0] value, value_next;
  logic                      last, last_next;

  assign i_dec = i - 1'b1;

  always_comb begin
    state_next = state;
    count_next = count;
    kq_next    = kq;
    i_next     = i;
    value_next = value;
    last_next  = last;
    mem_we     = 1'b0;
    mem_waddr  = i;
    mem_wdata  = value;
    mem_raddr  = '0;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          value_next = in_value;
          last_next  = in_last;
          kq_next    = k_eff;
          // trim to the current rank before inserting
          count_next = (count > k_eff) ? k_eff : count;
          state_next = S_START;
        end
      end
      S_START: begin
        if (count == kq) begin
          mem_raddr  = AW'(kq - 1'b1);
          i_next     = AW'(kq - 1'b1);
          state_next = S_CHKFULL;
        end else if (count == '0) begin
          i_next     = '0;
          count_next = count + 1'b1;
          state_next = S_PLACE;
        end else begin
          mem_raddr  = AW'(count - 1'b1);
          i_next     = AW'(count);
          count_next = count + 1'b1;
          state_next = S_STEP;
        end
      end
      S_CHKFULL: begin
        // full store: drop the new value unless it beats the smallest
        if (mem_rdata >= value) begin
          state_next = S_FINISH;
        end else if (i == '0) begin
          state_next = S_PLACE;
        end else begin
          mem_raddr  = i_dec;
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        mem_we = 1'b1;
        if (mem_rdata < value) begin
          // move the smaller entry down one slot
          mem_wdata = mem_rdata;
          i_next    = i_dec;
          if (i_dec == '0) begin
            state_next = S_PLACE;
          end else begin
            mem_raddr = i_dec - 1'b1;
          end
        end else begin
          state_next = S_FINISH;
        end
      end
      S_PLACE: begin
        mem_we     = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (last) begin
          mem_raddr  = AW'(count - 1'b1);
          state_next = S_FETCH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_FETCH: begin
        mem_raddr = AW'(count - 1'b1);
        res_valid = 1'b1;
        if (res_ready) begin
          count_next = '0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign res.kth_value = mem_rdata;
  assign res.short_set = (count < kq);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    kq    <= kq_next;
    i     <= i_next;
    value <= value_next;
    last  <= last_next;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    int'(count) <= KEEP_MAX)
    else $error("kept count above store depth");

  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> count != '0)
    else $error("result offered from an empty store");

  a_step_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> i != '0)
    else $error("shift step at the top slot");

  a_write_in_rank: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> int'(mem_waddr) < int'(kq))
    else $error("store write beyond current rank");
`endif

endmodule

// ===== test/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import kls_pkg::*;

  localparam int KEEP          = 16;    // store depth of the block
  localparam int RANDOM_ITEMS  = 800;   // random samples to queue
  localparam int SETTLE_CYCLES = 40;    // wait for an item that can still be in flight
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int QUIET_LIMIT   = 3000;  // cycles with no transfer before giving up
  localparam int REPORT_MAX    = 50;    // mismatch lines printed at most

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  localparam logic [RANK_W-1:0] RANK_TOP  = '1;  // above KEEP, must saturate
  localparam logic [RANK_W-1:0] RANK_ZERO = '0;  // acts as rank 1

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic                      last;
  } sample_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_we;
  logic [RANK_W-1:0] cfg_wdata;

  kls_in_if  in_if ();
  kls_out_if out_if ();

  kth_largest_selector #(
    .KEEP_MAX(KEEP)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .samples  (in_if),
    .results  (out_if)
  );

  // 10 ns clock
  always #5 clk = ~clk;

  // samples waiting to be offered, results waiting to come out
  sample_t pending_samples[$];
  result_t expected_results[$];

  // shadow copy of the selector state
  logic signed [VALUE_W-1:0] kept_vals [KEEP];
  int                        kept_n;
  logic [RANK_W-1:0]         rank_reg;

  int      errors;
  int      quiet_cycles;
  int      random_count;
  bit      in_took;
  int      src_gap;
  int      sink_stall;
  bit      src_idle;
  bit      snk_idle;
  int      hold_reqs;
  int      hold_seen;
  result_t oldest;

  // ---------------------------------------------------------------------------
  // top-k shadow model
  // ---------------------------------------------------------------------------

  // rank actually used: zero acts as one, anything past the store depth saturates
  function automatic int rank_in_use();
    int k;
    k = int'(rank_reg);
    if (k == 0) k = 1;
    if (k > KEEP) k = KEEP;
    return k;
  endfunction

  // fold one accepted sample into the kept list, high to low, and on the end of a
  // set queue the k-th largest
  function automatic void absorb_sample(logic signed [VALUE_W-1:0] v, logic last);
    int      k;
    int      pos;
    int      i;
    result_t r;
    k = rank_in_use();
    // rank lowered mid-set: the smallest entries fall off first
    if (kept_n > k) kept_n = k;
    // equal values land behind the ones already kept
    pos = 0;
    while (pos < kept_n && kept_vals[pos] >= v) pos++;
    if (pos < k) begin
      i = (kept_n < k) ? kept_n : k - 1;
      while (i > pos) begin
        kept_vals[i] = kept_vals[i-1];
        i--;
      end
      kept_vals[pos] = v;
      if (kept_n < k) kept_n++;
    end
    if (last) begin
      r.kth_value = kept_vals[kept_n-1];
      r.short_set = (kept_n < k);
      expected_results.push_back(r);
      kept_n = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // idle length: mostly a few cycles, now and then a long one
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return $urandom_range(1, 3);
    if (sel < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // style 1 gives heavy duplicates around zero, the rest mixes extremes with full range
  function automatic logic signed [VALUE_W-1:0] pick_value(int style);
    int sel;
    sel = $urandom_range(0, 9);
    if (style == 1) return $signed($urandom_range(0, 6)) - 3;
    if (sel == 0) return VALUE_MAX;
    if (sel == 1) return VALUE_MIN;
    if (sel == 2) return VALUE_MAX - $urandom_range(0, 3);
    if (sel == 3) return VALUE_MIN + $urandom_range(0, 3);
    return $urandom;
  endfunction

  // set length: mostly around the current rank so both short and full sets occur
  function automatic int pick_len();
    int sel;
    int k;
    sel = $urandom_range(0, 9);
    k = rank_in_use();
    if (sel < 6) return $urandom_range(1, k + 3);
    if (sel < 9) return $urandom_range(k, k + 3);
    return $urandom_range(1, 24);
  endfunction

  task automatic add_sample(logic signed [VALUE_W-1:0] v, logic last);
    sample_t s;
    s.value = v;
    s.last  = last;
    pending_samples.push_back(s);
  endtask

  // one set of random content; left open when close is 0
  task automatic queue_set(int len, bit close);
    int style;
    style = $urandom_range(0, 2);
    for (int i = 0; i < len; i++) begin
      add_sample(pick_value(style), close && (i == len - 1));
    end
    random_count += len;
  endtask

  // register write, only ever issued while the block is idle
  task automatic write_rank(logic [RANK_W-1:0] r);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_we    <= 1'b0;
    rank_reg = r;
  endtask

  // wait for every queued sample to transfer and every result to arrive, then let
  // an item with no result finish its walk through the store
  task automatic settle();
    @(posedge clk);
    while (pending_samples.size() != 0 || in_if.valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(string what);
    if (errors < REPORT_MAX) $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // sample driver: new values at the falling edge, transfer seen at the rising edge
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    in_took = !rst && in_if.valid && in_if.ready;
    if (in_took) absorb_sample(in_if.sample_value, in_if.set_end);
  end

  always @(negedge clk) begin
    sample_t s;
    if (rst) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (src_gap > 0) begin
        src_gap--;
        in_if.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        s = pending_samples.pop_front();
        in_if.valid        <= 1'b1;
        in_if.sample_value <= s.value;
        in_if.set_end      <= s.last;
        // idle after this one, if this phase idles at all
        src_gap = (src_idle && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result receiver: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen  = hold_reqs;
      sink_stall = HOLD_CYCLES;
    end
    if (rst) begin
      out_if.ready <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (snk_idle && $urandom_range(0, 3) == 0) sink_stall = pick_gap();
    end
  end

  // result monitor: every result transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d short_set %0b with nothing expected",
                                    out_if.kth_value, out_if.short_set));
        end else begin
          oldest = expected_results.pop_front();
          if (out_if.kth_value !== oldest.kth_value)
            report_mismatch($sformatf("kth_value got %0d want %0d",
                                      out_if.kth_value, oldest.kth_value));
          if (out_if.short_set !== oldest.short_set)
            report_mismatch($sformatf("short_set got %0b want %0b",
                                      out_if.short_set, oldest.short_set));
        end
      end
      // hang detection: any transfer on either side counts as progress
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("no transfer for %0d cycles", QUIET_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    int phase;
    int n_sets;
    int pick;
    logic [RANK_W-1:0] r;

    // everything known from time zero
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    in_if.valid        = 1'b0;
    in_if.sample_value = '0;
    in_if.set_end      = 1'b0;
    out_if.ready       = 1'b0;
    rank_reg           = 1;
    kept_n             = 0;
    errors             = 0;
    quiet_cycles       = 0;
    random_count       = 0;
    src_gap            = 0;
    sink_stall         = 0;
    hold_reqs          = 0;
    hold_seen          = 0;
    src_idle           = 1'b0;
    snk_idle           = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // rank left at its reset value of one: the maximum, across both extremes
    add_sample(VALUE_MAX, 1'b0);
    add_sample(VALUE_MIN, 1'b1);
    add_sample(-1, 1'b1);
    settle();

    // rank 4: duplicates kept separately, then sets shorter than k
    write_rank(4);
    add_sample(5, 1'b0);
    add_sample(5, 1'b0);
    add_sample(5, 1'b0);
    add_sample(-3, 1'b0);
    add_sample(5, 1'b1);
    add_sample(10, 1'b0);
    add_sample(20, 1'b1);
    add_sample(VALUE_MIN, 1'b0);
    add_sample(VALUE_MIN, 1'b1);
    settle();

    // rank zero behaves as rank one
    write_rank(RANK_ZERO);
    add_sample(3, 1'b0);
    add_sample(7, 1'b1);
    settle();

    // rank past the store depth saturates, short set reports its smallest
    write_rank(RANK_TOP);
    add_sample(VALUE_MAX, 1'b0);
    add_sample(-100, 1'b1);
    settle();

    // rank lowered in the middle of an open set: store trimmed before the next insert
    write_rank(8);
    for (int i = 8; i >= 1; i--) add_sample(i, 1'b0);
    settle();
    write_rank(2);
    add_sample(0, 1'b1);
    settle();

    // random phases, each with its own rank and idling pattern
    phase = 0;
    while (random_count < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 5);
      case (pick)
        0:       r = RANK_W'(1);
        1:       r = RANK_W'(KEEP);
        2:       r = RANK_TOP;
        3:       r = RANK_W'($urandom_range(KEEP + 1, 30));
        4:       r = RANK_ZERO;
        default: r = RANK_W'($urandom_range(2, KEEP - 1));
      endcase
      write_rank(r);
      src_idle = ($urandom_range(0, 3) != 0);
      snk_idle = ($urandom_range(0, 3) != 0);
      if (phase == 3) begin
        // receiver holds off while short sets keep coming: output register fills and
        // the sample side must stall
        src_idle = 1'b0;
        hold_reqs++;
        repeat (40) queue_set($urandom_range(1, 2), 1'b1);
      end else begin
        n_sets = $urandom_range(3, 8);
        repeat (n_sets) queue_set(pick_len(), 1'b1);
        // now and then the set stays open into the next rank setting
        if ($urandom_range(0, 3) == 0) queue_set($urandom_range(1, 10), 1'b0);
      end
      settle();
      phase++;
    end

    // close whatever set is still open
    queue_set(1, 1'b1);
    settle();

    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
